### hdl/wmf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmf_pkg
// Shared widths, register map and types of the weighted median filter.
// ----------------------------------------------------------------------------
package wmf_pkg;

    localparam int SMP_W       = 16;
    localparam int WT_W        = 16;
    localparam int PROD_W      = 32;
    localparam int SEEN_W      = 3;
    localparam int TAPS_W      = 3;
    localparam int HALF_W      = 2;
    localparam int NUM_WEIGHTS = 7;
    localparam int WIDX_W      = 3;
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;

    // register indexes (byte address is four times the index)
    localparam logic [WIDX_W-1:0] REG_ACTIVE_TAPS = 3'd0;
    localparam logic [WIDX_W-1:0] REG_WEIGHT_0    = 3'd1;

    localparam logic [TAPS_W-1:0] ACTIVE_TAPS_RST = 3'd5;
    localparam logic [WT_W-1:0]   WEIGHT_RST      = 16'd4096;

    typedef logic signed [SMP_W-1:0]  t_smp;
    typedef logic signed [WT_W-1:0]   t_wt;
    typedef logic signed [PROD_W-1:0] t_prod;

    // control that travels with one median job
    typedef struct packed {
        logic [HALF_W-1:0] h;
        logic              last;
    } t_job_ctl;

endpackage

### hdl/wmf_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmf_regs
// APB register file: window length and the seven tap weights.
// ----------------------------------------------------------------------------
module wmf_regs #(
    parameter int MAX_TAPS = 7
) (
    input  logic                                               i_clk,
    input  logic                                               i_rst_n,
    input  logic                                               psel,
    input  logic                                               penable,
    input  logic                                               pwrite,
    input  logic [wmf_pkg::ADDR_W-1:0]                         paddr,
    input  logic [wmf_pkg::DATA_W-1:0]                         pwdata,
    output logic [wmf_pkg::DATA_W-1:0]                         prdata,
    output logic                                               pready,
    output logic [wmf_pkg::NUM_WEIGHTS-1:0][wmf_pkg::WT_W-1:0] o_weight,
    output logic [wmf_pkg::HALF_W-1:0]                         o_h
);
    import wmf_pkg::*;

    logic [TAPS_W-1:0]                 r_active_taps;
    logic [NUM_WEIGHTS-1:0][WT_W-1:0]  r_weight;
    logic [WIDX_W-1:0]                 reg_idx;
    logic                              wr_en;
    logic [TAPS_W:0]                   win_len;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_taps <= ACTIVE_TAPS_RST;
            r_weight      <= {NUM_WEIGHTS{WEIGHT_RST}};
        end else if (wr_en) begin
            if (reg_idx == REG_ACTIVE_TAPS) begin
                r_active_taps <= pwdata[TAPS_W-1:0];
            end else begin
                r_weight[WIDX_W'(reg_idx - REG_WEIGHT_0)] <= pwdata[WT_W-1:0];
            end
        end
    end

    always_comb begin
        if (reg_idx == REG_ACTIVE_TAPS) begin
            prdata = {{(DATA_W-TAPS_W){1'b0}}, r_active_taps};
        end else begin
            prdata = {{(DATA_W-WT_W){1'b0}}, r_weight[WIDX_W'(reg_idx - REG_WEIGHT_0)]};
        end
    end

    // odd window length, limited to the lanes that exist
    always_comb begin
        win_len = {1'b0, r_active_taps} | (TAPS_W+1)'(1);
        if (win_len > (TAPS_W+1)'(MAX_TAPS)) begin
            win_len = (TAPS_W+1)'(MAX_TAPS);
        end
        if (!win_len[0]) begin
            win_len = win_len - (TAPS_W+1)'(1);
        end
    end

    assign o_h      = win_len[HALF_W:1];
    assign o_weight = r_weight;

endmodule

### hdl/wmf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmf_front
// Takes sample beats, keeps the window and turns completed windows into median jobs.
// ----------------------------------------------------------------------------
module wmf_front #(
    parameter int MAX_TAPS = 7
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    output logic                                     o_ready,
    input  logic [wmf_pkg::SMP_W-1:0]                i_sample_in,
    input  logic                                     i_end_of_stream,
    input  logic [wmf_pkg::HALF_W-1:0]               i_h,
    output logic                                     o_job_valid,
    input  logic                                     i_job_ready,
    output logic [MAX_TAPS-1:0][wmf_pkg::SMP_W-1:0]  o_job_smp,
    output wmf_pkg::t_job_ctl                        o_job_ctl
);
    import wmf_pkg::*;

    logic [MAX_TAPS-1:0][SMP_W-1:0] r_window, n_window;
    logic [SEEN_W-1:0]              r_seen, n_seen, seen_base;
    logic                           r_pend, n_pend;
    logic                           r_eos, n_eos;
    logic [HALF_W-1:0]              r_skip, n_skip;
    logic [HALF_W-1:0]              r_jobs, n_jobs;
    logic [HALF_W-1:0]              d0;
    logic                           push, fin, accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            r_pend <= 1'b0;
            r_eos  <= 1'b0;
            r_skip <= '0;
            r_jobs <= '0;
        end else begin
            r_seen <= n_seen;
            r_pend <= n_pend;
            r_eos  <= n_eos;
            r_skip <= n_skip;
            r_jobs <= n_jobs;
        end
    end

    always_ff @(posedge i_clk) begin
        r_window <= n_window;
    end

    always_comb begin
        push        = r_pend && (r_skip == '0) && i_job_ready;
        fin         = push && (r_jobs == '0);
        o_ready     = !r_pend || fin;
        accept      = i_valid && o_ready;
        o_job_valid = r_pend && (r_skip == '0);
        o_job_smp   = r_window;
        o_job_ctl.h    = i_h;
        o_job_ctl.last = r_eos && (r_jobs == '0);

        seen_base = (fin && r_eos) ? '0 : r_seen;
        d0 = (seen_base < SEEN_W'(i_h)) ? seen_base[HALF_W-1:0] : i_h;

        n_window = r_window;
        n_seen   = seen_base;
        n_pend   = r_pend;
        n_eos    = r_eos;
        n_skip   = r_skip;
        n_jobs   = r_jobs;

        // flushing: repeat the last sample to move the centre one step on
        if (r_pend && ((r_skip != '0) || (push && !fin))) begin
            n_window = {r_window[MAX_TAPS-2:0], r_window[0]};
        end
        if (r_skip != '0) begin
            n_skip = r_skip - HALF_W'(1);
        end
        if (push && !fin) begin
            n_jobs = r_jobs - HALF_W'(1);
        end
        if (fin) begin
            n_pend = 1'b0;
        end

        if (accept) begin
            // first beat of a stream fills every tap, so older taps repeat it
            if (seen_base == '0) begin
                n_window = {MAX_TAPS{i_sample_in}};
            end else begin
                n_window = {r_window[MAX_TAPS-2:0], i_sample_in};
            end
            if (seen_base < SEEN_W'(MAX_TAPS)) begin
                n_seen = seen_base + SEEN_W'(1);
            end
            if (i_end_of_stream) begin
                n_pend = 1'b1;
                n_eos  = 1'b1;
                n_skip = i_h - d0;
                n_jobs = d0;
            end else if (seen_base >= SEEN_W'(i_h)) begin
                n_pend = 1'b1;
                n_eos  = 1'b0;
                n_skip = '0;
                n_jobs = '0;
            end else begin
                n_pend = 1'b0;
                n_eos  = 1'b0;
            end
        end
    end

endmodule

### hdl/wmf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmf_queue
// Small register FIFO between the front and the back of the filter.
// ----------------------------------------------------------------------------
module wmf_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_ready = (r_cnt != CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

### hdl/wmf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmf_back
// Rank pipeline: weighted products, pairwise compare, rank select, output.
// ----------------------------------------------------------------------------
module wmf_back #(
    parameter int MAX_TAPS = 7
) (
    input  logic                                               i_clk,
    input  logic                                               i_rst_n,
    input  logic                                               i_job_valid,
    output logic                                               o_job_pop,
    input  logic [MAX_TAPS-1:0][wmf_pkg::SMP_W-1:0]            i_job_smp,
    input  wmf_pkg::t_job_ctl                                  i_job_ctl,
    input  logic [wmf_pkg::NUM_WEIGHTS-1:0][wmf_pkg::WT_W-1:0] i_weight,
    output logic                                               o_valid,
    input  logic                                               i_ready,
    output logic [wmf_pkg::SMP_W-1:0]                          o_filtered_sample,
    output logic                                               o_last_output
);
    import wmf_pkg::*;

    logic                adv;

    // stage 1: products
    t_prod               n_prod [MAX_TAPS];
    logic [MAX_TAPS-1:0] n_act;
    t_prod               r_prod [MAX_TAPS];
    t_smp                r_smp1 [MAX_TAPS];
    logic [MAX_TAPS-1:0] r_act1;
    t_job_ctl            r_ctl1;
    logic                r_v1;

    // stage 2: compare matrix, bit m of row r set when lane m ranks below lane r
    logic [MAX_TAPS-1:0] n_lt [MAX_TAPS];
    logic [MAX_TAPS-1:0] r_lt [MAX_TAPS];
    t_smp                r_smp2 [MAX_TAPS];
    logic [MAX_TAPS-1:0] r_act2;
    t_job_ctl            r_ctl2;
    logic                r_v2;

    // stage 3: output register
    logic [SMP_W-1:0]    n_out_smp;
    logic [SMP_W-1:0]    r_out_smp;
    logic                r_out_last;
    logic                r_v3;

    assign adv       = !r_v3 || i_ready;
    assign o_job_pop = adv && i_job_valid;

    // lane r holds window entry r, which is tap 2h-r of the centred window
    always_comb begin
        int   widx;
        t_smp sv;
        t_wt  wv;
        widx = 0;
        sv   = '0;
        wv   = '0;
        for (int r = 0; r < MAX_TAPS; r++) begin
            widx = 2 * int'(i_job_ctl.h) - r;
            sv   = t_smp'(i_job_smp[r]);
            if (widx >= 0) begin
                wv       = t_wt'(i_weight[WIDX_W'(widx)]);
                n_act[r] = 1'b1;
            end else begin
                wv       = '0;
                n_act[r] = 1'b0;
            end
            n_prod[r] = sv * wv;
        end
    end

    // equal products: the older tap, i.e. the higher lane, ranks lower
    always_comb begin
        for (int r = 0; r < MAX_TAPS; r++) begin
            for (int m = 0; m < MAX_TAPS; m++) begin
                n_lt[r][m] = r_act1[m] && ((r_prod[m] < r_prod[r]) ||
                             ((r_prod[m] == r_prod[r]) && (m > r)));
            end
        end
    end

    always_comb begin
        n_out_smp = '0;
        for (int r = 0; r < MAX_TAPS; r++) begin
            if (r_act2[r] && ($countones(r_lt[r]) == int'(r_ctl2.h))) begin
                n_out_smp = n_out_smp | r_smp2[r];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_job_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int r = 0; r < MAX_TAPS; r++) begin
                r_prod[r] <= n_prod[r];
                r_smp1[r] <= t_smp'(i_job_smp[r]);
                r_lt[r]   <= n_lt[r];
                r_smp2[r] <= r_smp1[r];
            end
            r_act1     <= n_act;
            r_ctl1     <= i_job_ctl;
            r_act2     <= r_act1;
            r_ctl2     <= r_ctl1;
            r_out_smp  <= n_out_smp;
            r_out_last <= r_ctl2.last;
        end
    end

    assign o_valid           = r_v3;
    assign o_filtered_sample = r_out_smp;
    assign o_last_output     = r_out_last;

endmodule

### hdl/weighted_median_filter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_median_filter_core
// Weighted median filter over a centred odd window of signed 16-bit samples.
// ----------------------------------------------------------------------------
// One sample beat is taken per clock while results are being taken; a result
// passes through the front, the queue and the three back stages. The front
// holds the window and issues one median job per result into a two-entry
// queue; the back is a three-stage rank pipeline (products, a full pairwise
// compare of all lanes, rank select into the output register) that takes one
// job per clock while its output is not stalled. An end-of-stream beat holds
// the front while it repeats the last sample to walk the window centre to the
// end and issues up to four jobs; the next beat is taken with the last job.
// The first h beats of a stream (h is half the window length) give no result
// unless one ends the stream. The user must write registers over the APB port
// only while no beat is in flight; the block itself does not enforce this.
module weighted_median_filter_core #(
    parameter int MAX_TAPS = 7
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [wmf_pkg::ADDR_W-1:0]   paddr,
    input  logic [wmf_pkg::DATA_W-1:0]   pwdata,
    output logic [wmf_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [wmf_pkg::SMP_W-1:0] i_sample_in,
    input  logic                         i_end_of_stream,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [wmf_pkg::SMP_W-1:0] o_filtered_sample,
    output logic                         o_last_output
);
    import wmf_pkg::*;

    localparam int JOB_W = MAX_TAPS * SMP_W + $bits(t_job_ctl);

    logic [NUM_WEIGHTS-1:0][WT_W-1:0] weight;
    logic [HALF_W-1:0]                half_len;

    logic                             f_valid, f_ready;
    logic [MAX_TAPS-1:0][SMP_W-1:0]   f_smp;
    t_job_ctl                         f_ctl;

    logic                             q_valid, q_pop;
    logic [JOB_W-1:0]                 q_data;
    logic [MAX_TAPS-1:0][SMP_W-1:0]   q_smp;
    t_job_ctl                         q_ctl;
    logic [SMP_W-1:0]                 out_smp;

    wmf_regs #(
        .MAX_TAPS (MAX_TAPS)
    ) u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_weight (weight),
        .o_h      (half_len)
    );

    wmf_front #(
        .MAX_TAPS (MAX_TAPS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_in_valid),
        .o_ready         (o_in_ready),
        .i_sample_in     (i_sample_in),
        .i_end_of_stream (i_end_of_stream),
        .i_h             (half_len),
        .o_job_valid     (f_valid),
        .i_job_ready     (f_ready),
        .o_job_smp       (f_smp),
        .o_job_ctl       (f_ctl)
    );

    wmf_queue #(
        .WIDTH (JOB_W),
        .DEPTH (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  ({f_ctl, f_smp}),
        .o_ready (f_ready),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_data)
    );

    assign {q_ctl, q_smp} = q_data;

    wmf_back #(
        .MAX_TAPS (MAX_TAPS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_job_valid       (q_valid),
        .o_job_pop         (q_pop),
        .i_job_smp         (q_smp),
        .i_job_ctl         (q_ctl),
        .i_weight          (weight),
        .o_valid           (o_out_valid),
        .i_ready           (i_out_ready),
        .o_filtered_sample (out_smp),
        .o_last_output     (o_last_output)
    );

    assign o_filtered_sample = out_smp;

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stream checker for weighted_median_filter_core. Sample beats come from a
// queue of pending beats. A built-in weighted median predictor turns every
// accepted beat into the medians it should release, and each output beat is
// compared against the oldest one still due. Directed streams cover the field
// extremes, the short and single-sample streams, pass-through, ties and a
// length change within a stream. Random streams then run under three
// back-pressure profiles, with one long output stall.
// ----------------------------------------------------------------------------
module tb;
    import wmf_pkg::*;

    localparam int TAPS = 7;

    typedef struct packed {
        t_smp value;
        logic eos;
    } t_beat;

    typedef struct packed {
        t_smp value;
        logic last;
    } t_median;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    t_smp              i_sample_in = '0;
    logic              i_end_of_stream = 1'b0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    t_smp              o_filtered_sample;
    logic              o_last_output;

    t_beat   pending_beats[$];
    t_median due_medians[$];
    int      send_idle = 0;
    int      recv_idle = 0;
    logic    out_hold = 1'b0;
    logic    hold_arm = 1'b0;
    int      mismatches = 0;

    // predictor state and shadow registers
    t_smp        win [TAPS];
    int          seen;
    logic [2:0]  taps_cfg;
    t_wt         wt_cfg [NUM_WEIGHTS];
    t_wt         wt_next [NUM_WEIGHTS];

    weighted_median_filter_core #(.MAX_TAPS(TAPS)) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_sample_in      (i_sample_in),
        .i_end_of_stream  (i_end_of_stream),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_filtered_sample(o_filtered_sample),
        .o_last_output    (o_last_output)
    );

    always #10 i_clk = ~i_clk;

    // median of the window centred d samples behind the newest
    function automatic t_smp weighted_median(int d, int w, int h);
        t_smp  s [TAPS];
        t_prod p [TAPS];
        int    k;
        int    rank;
        for (int j = 0; j < w; j++) begin
            k = d + h - j;
            if (k < 0) k = 0;
            if (k >= seen) k = seen - 1;
            if (k < 0) k = 0;
            if (k >= TAPS) k = TAPS - 1;
            s[j] = win[k];
            p[j] = t_prod'(s[j]) * t_prod'(wt_cfg[j]);
        end
        for (int j = 0; j < w; j++) begin
            rank = 0;
            // equal products: the earlier tap ranks lower
            for (int m = 0; m < w; m++) begin
                if (p[m] < p[j] || (p[m] == p[j] && m < j))
                    rank++;
            end
            if (rank == h)
                return s[j];
        end
        return '0;
    endfunction

    function automatic void advance_window(t_smp x, logic eos);
        int      w;
        int      h;
        int      prev;
        t_median r;
        w = int'(taps_cfg | 3'd1);
        h = w / 2;
        prev = seen;
        for (int k = TAPS - 1; k > 0; k--)
            win[k] = win[k - 1];
        win[0] = x;
        if (prev < TAPS)
            seen = prev + 1;
        if (eos) begin
            // flush every outstanding centre position
            for (int d = (prev < h) ? prev : h; d >= 0; d--) begin
                r.value = weighted_median(d, w, h);
                r.last = (d == 0);
                due_medians.push_back(r);
            end
            for (int k = 0; k < TAPS; k++)
                win[k] = '0;
            seen = 0;
        end else if (prev >= h) begin
            r.value = weighted_median(h, w, h);
            r.last = 1'b0;
            due_medians.push_back(r);
        end
    endfunction

    // sample driver
    always @(posedge i_clk) begin : drive_samples
        t_beat nb;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                advance_window(i_sample_in, i_end_of_stream);
            if (!i_in_valid || o_in_ready) begin
                if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle) begin
                    nb = pending_beats.pop_front();
                    i_in_valid <= 1'b1;
                    i_sample_in <= nb.value;
                    i_end_of_stream <= nb.eos;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and output back-pressure
    always @(posedge i_clk) begin : watch_results
        t_median want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (due_medians.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: got %0d last %0b",
                                 o_filtered_sample, o_last_output);
                end else begin
                    want = due_medians.pop_front();
                    if (want.value !== o_filtered_sample || want.last !== o_last_output) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: expected %0d last %0b, got %0d last %0b",
                                     want.value, want.last, o_filtered_sample, o_last_output);
                    end
                end
            end
            i_out_ready <= !out_hold && ($urandom_range(99) >= recv_idle);
        end
    end

    // long output stall so the pipe fills and the input backs up
    initial begin : long_stall
        wait (hold_arm);
        repeat (8) @(posedge i_clk);
        out_hold <= 1'b1;
        for (int n = 0; n < 120; n++)
            @(posedge i_clk);
        out_hold <= 1'b0;
    end

    initial begin : watchdog
        #2000000;
        $display("weighted_median_filter_core verification failed");
        $finish;
    end

    task automatic reg_write(input logic [WIDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_ACTIVE_TAPS)
            taps_cfg = val[2:0];
        else
            wt_cfg[idx - REG_WEIGHT_0] = val[WT_W-1:0];
    endtask

    task automatic program_filter(input logic [2:0] taps);
        reg_write(REG_ACTIVE_TAPS, {{(DATA_W-3){1'b0}}, taps});
        for (int j = 0; j < NUM_WEIGHTS; j++)
            reg_write(REG_WEIGHT_0 + WIDX_W'(j), {{(DATA_W-WT_W){1'b0}}, wt_next[j]});
    endtask

    // idle point: every beat taken, every result back, front end settled
    task automatic wait_drained();
        do @(posedge i_clk); while (pending_beats.size() != 0 || i_in_valid);
        while (due_medians.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    function automatic void queue_beat(t_smp v, logic eos);
        t_beat b;
        b.value = v;
        b.eos = eos;
        pending_beats.push_back(b);
    endfunction

    function automatic t_smp random_sample();
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(3))
                    0: return 16'sh7FFF;
                    1: return 16'sh8000;
                    2: return 16'sh0000;
                    default: return 16'shFFFF;
                endcase
            end
            1, 2, 3: return t_smp'($urandom_range(16)) - 16'sd8;
            default: return t_smp'($urandom);
        endcase
    endfunction

    function automatic t_wt random_weight();
        case ($urandom_range(7))
            0: return 16'sd4096;
            1: return 16'sd0;
            2: return 16'sh8000;
            3: return 16'sh7FFF;
            4: return t_wt'($urandom_range(8192)) - 16'sd4096;
            default: return t_wt'($urandom);
        endcase
    endfunction

    // random streams, mostly mid-length with a few very short ones
    function automatic void queue_streams(int beats);
        int len;
        int total;
        total = 0;
        while (total < beats) begin
            len = ($urandom_range(9) < 2) ? $urandom_range(1, 3) : $urandom_range(4, 25);
            for (int i = 0; i < len; i++)
                queue_beat(random_sample(), i == len - 1);
            total += len;
        end
    endfunction

    task automatic random_phase(input int s_idle, input int r_idle, input logic [2:0] taps);
        send_idle <= s_idle;
        recv_idle <= r_idle;
        for (int j = 0; j < NUM_WEIGHTS; j++)
            wt_next[j] = random_weight();
        program_filter(taps);
        queue_streams(83);
    endtask

    initial begin : main_flow
        int n;
        taps_cfg = ACTIVE_TAPS_RST;
        for (int j = 0; j < NUM_WEIGHTS; j++)
            wt_cfg[j] = WEIGHT_RST;
        for (int k = 0; k < TAPS; k++)
            win[k] = '0;
        seen = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // reset window of five, unit weights: extremes, then short streams
        queue_beat(16'sh7FFF, 1'b0);
        queue_beat(16'sh8000, 1'b0);
        queue_beat(16'sh0000, 1'b0);
        queue_beat(16'shFFFF, 1'b0);
        queue_beat(16'sh0001, 1'b0);
        queue_beat(16'sh5555, 1'b0);
        queue_beat(16'shAAAA, 1'b0);
        queue_beat(16'sh1234, 1'b1);
        queue_beat(16'sd100, 1'b1);
        queue_beat(-16'sd7, 1'b0);
        queue_beat(16'sd9, 1'b1);
        wait_drained();

        // zero length becomes one tap: straight pass-through
        wt_next[0] = 16'sh8000;
        wt_next[1] = 16'sh7FFF;
        for (int j = 2; j < NUM_WEIGHTS; j++)
            wt_next[j] = WEIGHT_RST;
        program_filter(3'd0);
        queue_beat(16'sd5, 1'b0);
        queue_beat(16'sh8000, 1'b0);
        queue_beat(16'sh7FFF, 1'b1);
        wait_drained();

        // all-zero weights tie everywhere, then the length drops mid-stream
        for (int j = 0; j < NUM_WEIGHTS; j++)
            wt_next[j] = '0;
        program_filter(3'd7);
        queue_beat(16'sd3, 1'b0);
        queue_beat(16'sd1, 1'b0);
        queue_beat(16'sd4, 1'b0);
        queue_beat(16'sd1, 1'b0);
        wait_drained();
        wt_next[0] = 16'sh7FFF;
        wt_next[1] = 16'sh8000;
        wt_next[2] = 16'shFFFF;
        program_filter(3'd3);
        queue_beat(16'sd5, 1'b0);
        queue_beat(16'sd9, 1'b0);
        queue_beat(-16'sd2, 1'b1);
        wait_drained();

        random_phase(18, 70, 3'd7);
        wait_drained();
        random_phase(70, 18, 3'($urandom_range(1, 6)));
        wait_drained();
        random_phase(0, 0, 3'($urandom_range(0, 7)));
        hold_arm = 1'b1;

        do @(posedge i_clk); while (pending_beats.size() != 0 || i_in_valid);
        for (n = 0; n < 5000 && due_medians.size() != 0; n++)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        mismatches += due_medians.size();

        if (mismatches == 0) begin
            $display("weighted_median_filter_core verification clean");
        end else begin
            $display("weighted_median_filter_core verification failed");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/wmf_pkg.sv
hdl/wmf_regs.sv
hdl/wmf_front.sv
hdl/wmf_queue.sv
hdl/wmf_back.sv
hdl/weighted_median_filter_core.sv
tb/tb.sv
